@@ design/mbt_pkg.sv @@
package mbt_pkg;

    localparam int FRAC_BITS_DEF = 28;
    localparam int COORD_W = 32;
    localparam int ITER_W = 16;
    localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = 16'd8000;

    // Width of one multiplier digit; each lane multiplies a full operand by one digit per cycle.
    localparam int DIGIT_W = 16;

    typedef struct packed {
        logic load;
        logic update;
        logic mul_load;
        logic mul_step;
        logic finish;
        logic emit;
    } mbt_cmd_t;

    typedef struct packed {
        logic escaped;
        logic limit;
        logic mul_last;
        logic in_set;
    } mbt_status_t;

endpackage

@@ design/mandelbrot_membership_test.sv @@
// Flow: an accepted input beat loads the point; each pass of the z update loop then runs check,
// update, multiplier load, the digit steps of the multiplier lanes, one per operand digit, with
// D = ceil((FRAC_BITS+2)/16) digits (D = 2 at FRAC_BITS = 28), and finish, until z escapes or the limit.
// Throughput: one point in flight; the next point is taken as soon as the result sits in the
// output register, while that result waits to be taken.
// Reset: synchronous, active low; clears control and sets the iteration limit to 8000.
module mandelbrot_membership_test import mbt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // [31:0] c_real, [63:32] c_imag
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [0] in_set, [7:1] zero
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ITER_W-1:0] cfg_data   // iteration limit
);

    logic [ITER_W-1:0] iter_limit_reg;
    logic              m_tvalid_reg;
    logic              in_set_reg;
    logic              out_free;
    mbt_cmd_t          cmd;
    mbt_status_t       status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_limit_reg <= ITER_LIMIT_RESET;
        end else if (cfg_valid) begin
            iter_limit_reg <= cfg_data;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    mbt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .out_free(out_free), .status(status), .cmd(cmd)
    );

    mbt_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
        .aclk(aclk), .cmd(cmd),
        .c_real($signed(s_tdata[COORD_W-1:0])),
        .c_imag($signed(s_tdata[2*COORD_W-1:COORD_W])),
        .iter_limit(iter_limit_reg), .status(status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            in_set_reg <= status.in_set;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, in_set_reg};

    a_one_point: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second point taken while one is in flight");

    a_update_after_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> !status.escaped && !status.limit)
        else $error("z updated after the loop should have ended");

    a_finish_after_last_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> $past(cmd.mul_step && status.mul_last))
        else $error("products taken before the last digit");

    a_emit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid && (m_tdata[0] == $past(status.in_set)))
        else $error("result beat does not match the finished point");

endmodule

@@ design/mbt_mul.sv @@
module mbt_mul import mbt_pkg::*; #(
    parameter int OP_W = FRAC_BITS_DEF + 2,
    parameter int NUM_DIGITS = (FRAC_BITS_DEF + 2 + DIGIT_W - 1) / DIGIT_W
) (
    input  logic                               aclk,
    input  logic                               load,
    input  logic                               step,
    input  logic [OP_W-1:0]                    op_a,
    input  logic [OP_W-1:0]                    op_b,
    output logic [OP_W+NUM_DIGITS*DIGIT_W-1:0] prod
);

    localparam int BW = NUM_DIGITS * DIGIT_W;
    localparam int PW = OP_W + BW;
    localparam int PP_W = OP_W + DIGIT_W;

    logic [OP_W-1:0] a_reg;
    logic [BW-1:0]   b_reg;
    logic [PW-1:0]   acc_reg;
    logic [PP_W-1:0] partial;

    // Digits of b are taken from the top down, so the accumulator only ever shifts by a constant.
    assign partial = PP_W'(a_reg) * PP_W'(b_reg[BW-1 -: DIGIT_W]);

    always_ff @(posedge aclk) begin
        if (load) begin
            a_reg   <= op_a;
            b_reg   <= BW'(op_b);
            acc_reg <= '0;
        end else if (step) begin
            b_reg   <= b_reg << DIGIT_W;
            acc_reg <= (acc_reg << DIGIT_W) + PW'(partial);
        end
    end

    assign prod = acc_reg;

endmodule

@@ design/mbt_datapath.sv @@
module mbt_datapath import mbt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  mbt_cmd_t                  cmd,
    input  logic signed [COORD_W-1:0] c_real,
    input  logic signed [COORD_W-1:0] c_imag,
    input  logic [ITER_W-1:0]         iter_limit,
    output mbt_status_t               status
);

    localparam int VAL_W = ((FRAC_BITS + 3 > COORD_W - 1) ? FRAC_BITS + 3 : COORD_W - 1) + 2;
    localparam int OP_W = FRAC_BITS + 2;
    localparam int SQ_W = FRAC_BITS + 4;
    localparam int NUM_DIGITS = (OP_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PW = OP_W + NUM_DIGITS * DIGIT_W;
    localparam int DCNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int SQQ_W = PW - FRAC_BITS;
    localparam int XYQ_W = PW - FRAC_BITS + 1;
    localparam logic [SQ_W-1:0] CAP = {1'b1, {(SQ_W-1){1'b0}}};
    localparam logic [SQ_W:0] FOUR = {3'b001, {(FRAC_BITS+2){1'b0}}};

    logic signed [COORD_W-1:0] cr_reg, ci_reg;
    logic signed [VAL_W-1:0]   x_reg, y_reg;
    logic [SQ_W-1:0]           x2_reg, y2_reg, m_reg;
    logic                      neg_reg, xbig_reg, ybig_reg;
    logic [ITER_W-1:0]         count_reg;
    logic [DCNT_W-1:0]         dcnt_reg;

    logic [VAL_W-1:0]        mag_x, mag_y;
    logic signed [VAL_W-1:0] cross_s, cr_ext, ci_ext, x_new, y_new;
    logic [PW-1:0]           prod_xx, prod_yy, prod_xy;
    logic [SQQ_W-1:0]        xx_q, yy_q;
    logic [XYQ_W-1:0]        xy_q;
    logic [SQ_W-1:0]         x2_fin, y2_fin, m_fin;
    logic [SQ_W:0]           sq_sum;

    assign mag_x = x_reg[VAL_W-1] ? $unsigned(-x_reg) : $unsigned(x_reg);
    assign mag_y = y_reg[VAL_W-1] ? $unsigned(-y_reg) : $unsigned(y_reg);

    assign cr_ext = {{(VAL_W-COORD_W){cr_reg[COORD_W-1]}}, cr_reg};
    assign ci_ext = {{(VAL_W-COORD_W){ci_reg[COORD_W-1]}}, ci_reg};
    assign cross_s = neg_reg ? -$signed(VAL_W'(m_reg)) : $signed(VAL_W'(m_reg));
    assign y_new = cross_s + ci_ext;
    assign x_new = $signed(VAL_W'(x2_reg)) - $signed(VAL_W'(y2_reg)) + cr_ext;

    mbt_mul #(.OP_W(OP_W), .NUM_DIGITS(NUM_DIGITS)) u_mul_xx (
        .aclk(aclk), .load(cmd.mul_load), .step(cmd.mul_step),
        .op_a(mag_x[OP_W-1:0]), .op_b(mag_x[OP_W-1:0]), .prod(prod_xx)
    );

    mbt_mul #(.OP_W(OP_W), .NUM_DIGITS(NUM_DIGITS)) u_mul_yy (
        .aclk(aclk), .load(cmd.mul_load), .step(cmd.mul_step),
        .op_a(mag_y[OP_W-1:0]), .op_b(mag_y[OP_W-1:0]), .prod(prod_yy)
    );

    // The cross term is only used while the point has not escaped, and then both
    // magnitudes fit the operand width, so truncating them here is harmless.
    mbt_mul #(.OP_W(OP_W), .NUM_DIGITS(NUM_DIGITS)) u_mul_xy (
        .aclk(aclk), .load(cmd.mul_load), .step(cmd.mul_step),
        .op_a(mag_x[OP_W-1:0]), .op_b(mag_y[OP_W-1:0]), .prod(prod_xy)
    );

    assign xx_q = prod_xx[PW-1:FRAC_BITS];
    assign yy_q = prod_yy[PW-1:FRAC_BITS];
    assign xy_q = prod_xy[PW-1:FRAC_BITS-1];

    // An operand too wide for the lane squares to far more than the cap.
    assign x2_fin = (xbig_reg || xx_q > SQQ_W'(CAP)) ? CAP : xx_q[SQ_W-1:0];
    assign y2_fin = (ybig_reg || yy_q > SQQ_W'(CAP)) ? CAP : yy_q[SQ_W-1:0];
    assign m_fin  = (xy_q > XYQ_W'(CAP)) ? CAP : xy_q[SQ_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cr_reg    <= c_real;
            ci_reg    <= c_imag;
            x_reg     <= '0;
            y_reg     <= '0;
            x2_reg    <= '0;
            y2_reg    <= '0;
            m_reg     <= '0;
            neg_reg   <= 1'b0;
            count_reg <= '0;
        end
        if (cmd.update) begin
            x_reg     <= x_new;
            y_reg     <= y_new;
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.mul_load) begin
            xbig_reg <= |mag_x[VAL_W-1:OP_W];
            ybig_reg <= |mag_y[VAL_W-1:OP_W];
            neg_reg  <= x_reg[VAL_W-1] ^ y_reg[VAL_W-1];
            dcnt_reg <= '0;
        end else if (cmd.mul_step) begin
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.finish) begin
            x2_reg <= x2_fin;
            y2_reg <= y2_fin;
            m_reg  <= m_fin;
        end
    end

    assign sq_sum = (SQ_W+1)'(x2_reg) + (SQ_W+1)'(y2_reg);

    assign status.escaped  = sq_sum > FOUR;
    assign status.limit    = !(count_reg < iter_limit);
    assign status.in_set   = count_reg == iter_limit;
    assign status.mul_last = dcnt_reg == DCNT_W'(NUM_DIGITS - 1);

endmodule

@@ design/mbt_ctrl.sv @@
module mbt_ctrl import mbt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        out_free,
    input  mbt_status_t status,
    output mbt_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_UPDATE = 7'b0000100,
        S_LOAD   = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_FINISH = 7'b0100000,
        S_DONE   = 7'b1000000
    } mbt_state_t;

    mbt_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (status.escaped || status.limit) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                cmd.mul_load = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                if (status.mul_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = S_CHECK;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
